// ----- rtl/core/bitplane_framebuffer_refresh_top_defines.svh -----
// Assertion macros for the bitplane framebuffer refresh block.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef BITPLANE_FRAMEBUFFER_REFRESH_TOP_DEFINES_SVH
`define BITPLANE_FRAMEBUFFER_REFRESH_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define BFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define BFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bfr_pkg.sv -----
// Shared types and constants of the bitplane framebuffer refresh block.
// No dependencies; used by the controller, the datapath and the top level.
package bfr_pkg;

  localparam int FULL_WIDTH_DEF     = 128;
  localparam int FULL_HEIGHT_DEF    = 64;
  localparam int LOW_WIDTH_DEF      = 64;
  localparam int LOW_HEIGHT_DEF     = 32;
  localparam int SEGMENT_PIXELS_DEF = 32;

  localparam int OPCODE_W    = 3;
  localparam int PIXEL_X_W   = 7;
  localparam int PIXEL_Y_W   = 6;
  localparam int SEGMENT_W   = 2;
  localparam int KIND_W      = 2;
  localparam int COORD_W     = 8;
  localparam int SIZE_W      = 2;
  localparam int COLOR_W     = 16;
  localparam int PLANE_W     = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [PLANE_W-1:0] plane_t;
  typedef logic [SIZE_W-1:0]  size_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TOGGLE   = 3'd0,
    OP_CLEAR    = 3'd1,
    OP_DRAW     = 3'd2,
    OP_LOW_RES  = 3'd3,
    OP_HIGH_RES = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESP = 2'd0,
    KIND_RECT = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PLANE_SELECT     = 3'd0,
    CFG_BACKGROUND_COLOR = 3'd1,
    CFG_PLANE0_COLOR     = 3'd2,
    CFG_PLANE1_COLOR     = 3'd3,
    CFG_BOTH_COLOR       = 3'd4,
    CFG_ORIGIN_X         = 3'd5,
    CFG_ORIGIN_Y         = 3'd6
  } cfg_idx_t;

  // What the read-back stage does with the data it receives
  typedef enum logic [1:0] {
    PIPE_NONE   = 2'd0,
    PIPE_TOGGLE = 2'd1,
    PIPE_CLEAR  = 2'd2,
    PIPE_DRAW   = 2'd3
  } pipe_t;

  // Extent of a sweep over the stores
  typedef enum logic [1:0] {
    BOUND_FULL    = 2'd0,
    BOUND_VISIBLE = 2'd1,
    BOUND_SEGMENT = 2'd2
  } bound_t;

  typedef struct packed {
    logic   load;
    logic   init_wr;
    logic   rd;
    logic   step;
    pipe_t  pipe;
    bound_t bound;
    logic   emit_done;
    logic   emit_mode;
    logic   mode_high;
  } cmd_t;

  typedef struct packed {
    logic last_full;
    logic last_visible;
    logic last_segment;
    logic scan_empty;
  } status_t;

endpackage

// ----- rtl/core/bitplane_framebuffer_refresh_top.sv -----
// Top level of the bitplane framebuffer refresh block.
// Instantiates bfr_ctrl and bfr_datapath; uses bfr_pkg and the defines header.
//
//   channel  handshake             beat
//   in_      start & !busy         opcode, pixel_x, pixel_y, segment
//   out_     out_strobe (1 cycle)  kind, collision, rect_x/y, rect_size, color, last
//   cfg_     cfg_we                cfg_index, cfg_data
//
// Draw reads the pixels of the segment that lie inside the visible area
// (SEGMENT_PIXELS at most, possibly none), clear the visible width * height
// entries; one store entry is read per cycle.
// After reset a clearing pass over all FULL_WIDTH * FULL_HEIGHT entries zeroes both
// stores with busy held high; cfg writes are taken throughout.
// Results are one-cycle strobes; the receiver cannot stall them.
`include "bitplane_framebuffer_refresh_top_defines.svh"

module bitplane_framebuffer_refresh_top #(
  parameter int FULL_WIDTH     = bfr_pkg::FULL_WIDTH_DEF,
  parameter int FULL_HEIGHT    = bfr_pkg::FULL_HEIGHT_DEF,
  parameter int LOW_WIDTH      = bfr_pkg::LOW_WIDTH_DEF,
  parameter int LOW_HEIGHT     = bfr_pkg::LOW_HEIGHT_DEF,
  parameter int SEGMENT_PIXELS = bfr_pkg::SEGMENT_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bfr_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [bfr_pkg::PIXEL_X_W-1:0]   in_pixel_x,
  input  logic [bfr_pkg::PIXEL_Y_W-1:0]   in_pixel_y,
  input  logic [bfr_pkg::SEGMENT_W-1:0]   in_segment,
  output logic                            out_strobe,
  output logic [bfr_pkg::KIND_W-1:0]      out_kind,
  output logic                            out_collision,
  output logic [bfr_pkg::COORD_W-1:0]     out_rect_x,
  output logic [bfr_pkg::COORD_W-1:0]     out_rect_y,
  output logic [bfr_pkg::SIZE_W-1:0]      out_rect_size,
  output logic [bfr_pkg::COLOR_W-1:0]     out_color,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [bfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bfr_pkg::cmd_t    cmd;
  bfr_pkg::status_t status;

  bfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  bfr_datapath #(
    .FULL_WIDTH     (FULL_WIDTH),
    .FULL_HEIGHT    (FULL_HEIGHT),
    .LOW_WIDTH      (LOW_WIDTH),
    .LOW_HEIGHT     (LOW_HEIGHT),
    .SEGMENT_PIXELS (SEGMENT_PIXELS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_opcode     (in_opcode),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_segment    (in_segment),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_strobe    (out_strobe),
    .out_kind      (out_kind),
    .out_collision (out_collision),
    .out_rect_x    (out_rect_x),
    .out_rect_y    (out_rect_y),
    .out_rect_size (out_rect_size),
    .out_color     (out_color),
    .out_last      (out_last)
  );

  // only rectangle beats leave last low
  `BFR_ASSERT_NOW(a_rect_not_last, out_strobe && !out_last, out_kind == bfr_pkg::KIND_RECT, "non-rectangle beat without last")

  // a mode op answers in the following cycle
  `BFR_ASSERT_NEXT(a_mode_resp, start && !busy && (in_opcode == bfr_pkg::OP_LOW_RES || in_opcode == bfr_pkg::OP_HIGH_RES), out_strobe && out_last && out_kind == bfr_pkg::KIND_RESP, "mode op gave no response")

  // a toggle answers through S_TOGGLE, the read-back stage and the result register
  `BFR_ASSERT_NEXT(a_toggle_resp, start && !busy && in_opcode == bfr_pkg::OP_TOGGLE, ##2 (out_strobe && out_last && out_kind == bfr_pkg::KIND_RESP), "toggle response missing")

  // the clearing pass never overlaps a scan or a result
  `BFR_ASSERT_NOW(a_init_exclusive, cmd.init_wr, !cmd.rd && !cmd.emit_done && !cmd.emit_mode, "store clear overlaps other work")

endmodule

// ----- rtl/core/bfr_ctrl.sv -----
// Sequencer of the bitplane framebuffer refresh block.
// Drives the datapath by bfr_pkg::cmd_t and reads back bfr_pkg::status_t.
module bfr_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bfr_pkg::OPCODE_W-1:0]  in_opcode,
  input  bfr_pkg::status_t              status,
  output bfr_pkg::cmd_t                 cmd,
  output logic                          busy
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_TOGGLE,
    S_TOGGLE_WAIT,
    S_CLEAR,
    S_DRAW,
    S_SCAN_WAIT,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic        busy_r;
  bfr_pkg::op_t op;

  assign op   = bfr_pkg::op_t'(in_opcode);
  assign busy = busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        // zero both stores, one entry a cycle
        cmd.init_wr = 1'b1;
        cmd.step    = 1'b1;
        cmd.bound   = bfr_pkg::BOUND_FULL;
        if (status.last_full) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (op) inside
            bfr_pkg::OP_TOGGLE: state_nxt = S_TOGGLE;
            bfr_pkg::OP_CLEAR:  state_nxt = S_CLEAR;
            bfr_pkg::OP_DRAW:   state_nxt = S_DRAW;
            bfr_pkg::OP_LOW_RES, bfr_pkg::OP_HIGH_RES: begin
              cmd.emit_mode = 1'b1;
              cmd.mode_high = (op == bfr_pkg::OP_HIGH_RES);
            end
            default: ;
          endcase
        end
      end
      S_TOGGLE: begin
        cmd.rd    = 1'b1;
        cmd.pipe  = bfr_pkg::PIPE_TOGGLE;
        state_nxt = S_TOGGLE_WAIT;
      end
      S_TOGGLE_WAIT: begin
        // hold off new items while the write-back beat goes out
        state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        cmd.rd    = 1'b1;
        cmd.step  = 1'b1;
        cmd.pipe  = bfr_pkg::PIPE_CLEAR;
        cmd.bound = bfr_pkg::BOUND_VISIBLE;
        if (status.last_visible) begin
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_DRAW: begin
        if (status.scan_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd    = 1'b1;
          cmd.step  = 1'b1;
          cmd.pipe  = bfr_pkg::PIPE_DRAW;
          cmd.bound = bfr_pkg::BOUND_SEGMENT;
          if (status.last_segment) begin
            state_nxt = S_SCAN_WAIT;
          end
        end
      end
      S_SCAN_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.emit_done = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

endmodule

// ----- rtl/core/bfr_datapath.sv -----
// Datapath: pixel and shadow stores, sweep counters, read-back stage,
// configuration registers and result registers. Uses bfr_pkg.
module bfr_datapath #(
  parameter int FULL_WIDTH     = bfr_pkg::FULL_WIDTH_DEF,
  parameter int FULL_HEIGHT    = bfr_pkg::FULL_HEIGHT_DEF,
  parameter int LOW_WIDTH      = bfr_pkg::LOW_WIDTH_DEF,
  parameter int LOW_HEIGHT     = bfr_pkg::LOW_HEIGHT_DEF,
  parameter int SEGMENT_PIXELS = bfr_pkg::SEGMENT_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bfr_pkg::cmd_t                   cmd,
  output bfr_pkg::status_t                status,
  input  logic [bfr_pkg::OPCODE_W-1:0]    in_opcode,
  input  logic [bfr_pkg::PIXEL_X_W-1:0]   in_pixel_x,
  input  logic [bfr_pkg::PIXEL_Y_W-1:0]   in_pixel_y,
  input  logic [bfr_pkg::SEGMENT_W-1:0]   in_segment,
  input  logic                            cfg_we,
  input  logic [bfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_strobe,
  output logic [bfr_pkg::KIND_W-1:0]      out_kind,
  output logic                            out_collision,
  output logic [bfr_pkg::COORD_W-1:0]     out_rect_x,
  output logic [bfr_pkg::COORD_W-1:0]     out_rect_y,
  output logic [bfr_pkg::SIZE_W-1:0]      out_rect_size,
  output logic [bfr_pkg::COLOR_W-1:0]     out_color,
  output logic                            out_last
);

  localparam int XRange = 1 << bfr_pkg::PIXEL_X_W;
  localparam int YRange = 1 << bfr_pkg::PIXEL_Y_W;
  localparam int ColMax = (FULL_WIDTH > XRange) ? FULL_WIDTH : XRange;
  localparam int RowMax = (FULL_HEIGHT > YRange) ? FULL_HEIGHT : YRange;
  localparam int CW     = $clog2(ColMax + 1);
  localparam int RW     = $clog2(RowMax + 1);
  localparam int Depth  = FULL_WIDTH * FULL_HEIGHT;
  localparam int AW     = $clog2(Depth);
  localparam int LowW   = (LOW_WIDTH < FULL_WIDTH) ? LOW_WIDTH : FULL_WIDTH;
  localparam int LowH   = (LOW_HEIGHT < FULL_HEIGHT) ? LOW_HEIGHT : FULL_HEIGHT;

  localparam bfr_pkg::plane_t PixNone   = 2'b00;
  localparam bfr_pkg::plane_t PixPlane0 = 2'b01;
  localparam bfr_pkg::plane_t PixPlane1 = 2'b10;
  localparam bfr_pkg::size_t  SizeHigh  = 2'd1;
  localparam bfr_pkg::size_t  SizeLow   = 2'd2;

  localparam bfr_pkg::plane_t PlaneSelectRst = 2'd1;
  localparam bfr_pkg::color_t ColorRst       = 16'd0;
  localparam bfr_pkg::coord_t OriginXRst     = 8'd1;
  localparam bfr_pkg::coord_t OriginYRst     = 8'd32;

  // configuration
  bfr_pkg::plane_t plane_select_r;
  bfr_pkg::color_t background_color_r, plane0_color_r, plane1_color_r, both_color_r;
  bfr_pkg::coord_t origin_x_r, origin_y_r;
  logic            hr_r;

  // sweep position
  logic [CW-1:0]                 col_r, col_nxt, col_end;
  logic [RW-1:0]                 row_r, row_nxt;
  logic [bfr_pkg::SEGMENT_W-1:0] seg_r;
  logic [CW-1:0]                 vis_w, seg_start, seg_top, seg_end;
  logic [RW-1:0]                 vis_h;
  logic [AW-1:0]                 addr;

  // stores
  bfr_pkg::plane_t pix_mem [Depth];
  bfr_pkg::plane_t shd_mem [Depth];
  bfr_pkg::plane_t pix_rd_r, shd_rd_r;
  logic            pix_we, shd_we;
  logic [AW-1:0]   wr_addr;
  bfr_pkg::plane_t pix_wd, shd_wd;

  // read-back stage
  bfr_pkg::pipe_t  p1_pipe_r;
  logic [AW-1:0]   p1_addr_r;
  logic [CW-1:0]   p1_col_r;
  logic [RW-1:0]   p1_row_r;
  logic            p1_in_range_r;

  // results
  logic             out_strobe_r, out_strobe_nxt;
  bfr_pkg::kind_t   out_kind_r, out_kind_nxt;
  logic             out_collision_r, out_collision_nxt;
  bfr_pkg::coord_t  out_rect_x_r, out_rect_x_nxt, out_rect_y_r, out_rect_y_nxt;
  bfr_pkg::size_t   out_rect_size_r, out_rect_size_nxt;
  bfr_pkg::color_t  out_color_r, out_color_nxt;
  logic             out_last_r, out_last_nxt;
  bfr_pkg::coord_t  scaled_x, scaled_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_select_r     <= PlaneSelectRst;
      background_color_r <= ColorRst;
      plane0_color_r     <= ColorRst;
      plane1_color_r     <= ColorRst;
      both_color_r       <= ColorRst;
      origin_x_r         <= OriginXRst;
      origin_y_r         <= OriginYRst;
    end else if (cfg_we) begin
      unique case (bfr_pkg::cfg_idx_t'(cfg_index))
        bfr_pkg::CFG_PLANE_SELECT:     plane_select_r     <= bfr_pkg::plane_t'(cfg_data);
        bfr_pkg::CFG_BACKGROUND_COLOR: background_color_r <= bfr_pkg::color_t'(cfg_data);
        bfr_pkg::CFG_PLANE0_COLOR:     plane0_color_r     <= bfr_pkg::color_t'(cfg_data);
        bfr_pkg::CFG_PLANE1_COLOR:     plane1_color_r     <= bfr_pkg::color_t'(cfg_data);
        bfr_pkg::CFG_BOTH_COLOR:       both_color_r       <= bfr_pkg::color_t'(cfg_data);
        bfr_pkg::CFG_ORIGIN_X:         origin_x_r         <= bfr_pkg::coord_t'(cfg_data);
        bfr_pkg::CFG_ORIGIN_Y:         origin_y_r         <= bfr_pkg::coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hr_r <= 1'b0;
    end else if (cmd.emit_mode) begin
      hr_r <= cmd.mode_high;
    end
  end

  assign vis_w     = hr_r ? CW'(FULL_WIDTH) : CW'(LowW);
  assign vis_h     = hr_r ? RW'(FULL_HEIGHT) : RW'(LowH);
  assign seg_start = CW'(seg_r) * CW'(SEGMENT_PIXELS);
  assign seg_top   = seg_start + CW'(SEGMENT_PIXELS);
  // a segment that runs past the visible edge stops there
  assign seg_end   = (seg_top < vis_w) ? seg_top : vis_w;

  assign status.last_full    = (col_r == CW'(FULL_WIDTH - 1)) && (row_r == RW'(FULL_HEIGHT - 1));
  assign status.last_visible = (col_r == vis_w - CW'(1)) && (row_r == vis_h - RW'(1));
  assign status.last_segment = (col_r == seg_end - CW'(1));
  assign status.scan_empty   = (row_r >= vis_h) || (col_r >= seg_end);

  always_comb begin
    unique case (cmd.bound)
      bfr_pkg::BOUND_FULL:    col_end = CW'(FULL_WIDTH);
      bfr_pkg::BOUND_VISIBLE: col_end = vis_w;
      default:                col_end = seg_end;
    endcase
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.load) begin
      unique case (bfr_pkg::op_t'(in_opcode))
        bfr_pkg::OP_TOGGLE: begin
          col_nxt = CW'(in_pixel_x);
          row_nxt = RW'(in_pixel_y);
        end
        bfr_pkg::OP_DRAW: begin
          col_nxt = CW'(in_segment) * CW'(SEGMENT_PIXELS);
          row_nxt = RW'(in_pixel_y);
        end
        default: begin
          col_nxt = '0;
          row_nxt = '0;
        end
      endcase
    end else if (cmd.step) begin
      if (col_r == col_end - CW'(1)) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seg_r <= in_segment;
    end
  end

  assign addr = AW'(32'(row_r) * 32'(FULL_WIDTH) + 32'(col_r));

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      pix_rd_r <= pix_mem[addr];
      shd_rd_r <= shd_mem[addr];
    end
  end

  always_comb begin
    pix_we  = 1'b0;
    shd_we  = 1'b0;
    pix_wd  = pix_rd_r;
    shd_wd  = pix_rd_r;
    wr_addr = p1_addr_r;
    if (cmd.init_wr) begin
      pix_we  = 1'b1;
      shd_we  = 1'b1;
      pix_wd  = '0;
      shd_wd  = '0;
      wr_addr = addr;
    end else begin
      case (p1_pipe_r)
        bfr_pkg::PIPE_TOGGLE: begin
          pix_we = p1_in_range_r;
          pix_wd = pix_rd_r ^ plane_select_r;
        end
        bfr_pkg::PIPE_CLEAR: begin
          // shadow takes the old pixel, then drop the selected planes
          shd_we = 1'b1;
          pix_we = 1'b1;
          pix_wd = pix_rd_r & ~plane_select_r;
        end
        bfr_pkg::PIPE_DRAW: begin
          shd_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[wr_addr] <= pix_wd;
    end
    if (shd_we) begin
      shd_mem[wr_addr] <= shd_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_pipe_r <= bfr_pkg::PIPE_NONE;
    end else begin
      p1_pipe_r <= cmd.rd ? cmd.pipe : bfr_pkg::PIPE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      p1_addr_r     <= addr;
      p1_col_r      <= col_r;
      p1_row_r      <= row_r;
      p1_in_range_r <= (col_r < CW'(FULL_WIDTH)) && (row_r < RW'(FULL_HEIGHT));
    end
  end

  assign scaled_x = hr_r ? bfr_pkg::coord_t'(p1_col_r) : bfr_pkg::coord_t'({p1_col_r, 1'b0});
  assign scaled_y = hr_r ? bfr_pkg::coord_t'(p1_row_r) : bfr_pkg::coord_t'({p1_row_r, 1'b0});

  always_comb begin
    out_strobe_nxt    = 1'b0;
    out_kind_nxt      = bfr_pkg::KIND_RESP;
    out_collision_nxt = 1'b0;
    out_rect_x_nxt    = '0;
    out_rect_y_nxt    = '0;
    out_rect_size_nxt = '0;
    out_color_nxt     = '0;
    out_last_nxt      = 1'b0;
    if (cmd.emit_done) begin
      out_strobe_nxt = 1'b1;
      out_kind_nxt   = bfr_pkg::KIND_DONE;
      out_last_nxt   = 1'b1;
    end else if (cmd.emit_mode) begin
      out_strobe_nxt = 1'b1;
      out_last_nxt   = 1'b1;
    end else begin
      case (p1_pipe_r)
        bfr_pkg::PIPE_TOGGLE: begin
          out_strobe_nxt    = 1'b1;
          out_last_nxt      = 1'b1;
          out_collision_nxt = p1_in_range_r && ((pix_rd_r & plane_select_r) != PixNone);
        end
        bfr_pkg::PIPE_DRAW: begin
          if (pix_rd_r != shd_rd_r) begin
            out_strobe_nxt    = 1'b1;
            out_kind_nxt      = bfr_pkg::KIND_RECT;
            out_rect_x_nxt    = scaled_x + origin_x_r;
            out_rect_y_nxt    = scaled_y + origin_y_r;
            out_rect_size_nxt = hr_r ? SizeHigh : SizeLow;
            case (pix_rd_r)
              PixNone:   out_color_nxt = background_color_r;
              PixPlane0: out_color_nxt = plane0_color_r;
              PixPlane1: out_color_nxt = plane1_color_r;
              default:   out_color_nxt = both_color_r;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r      <= out_kind_nxt;
    out_collision_r <= out_collision_nxt;
    out_rect_x_r    <= out_rect_x_nxt;
    out_rect_y_r    <= out_rect_y_nxt;
    out_rect_size_r <= out_rect_size_nxt;
    out_color_r     <= out_color_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_kind      = out_kind_r;
  assign out_collision = out_collision_r;
  assign out_rect_x    = out_rect_x_r;
  assign out_rect_y    = out_rect_y_r;
  assign out_rect_size = out_rect_size_r;
  assign out_color     = out_color_r;
  assign out_last      = out_last_r;

endmodule
